/* hdl/rc4sc_pkg.sv */
`default_nettype none

package rc4sc_pkg;

    // permutation table geometry
    localparam int TABLE_SIZE     = 256;
    localparam int TABLE_AW       = 8;
    localparam int BYTE_W         = 8;

    // default key store depth
    localparam int KEY_BYTES_MAX_DEF = 256;

    // request kinds carried on the input tuser
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    // last entry of the permutation table
    localparam logic [TABLE_AW-1:0] TABLE_LAST = TABLE_AW'(TABLE_SIZE - 1);

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_KSA_RD,
        ST_KSA_J,
        ST_KSA_WN,
        ST_KSA_WJ,
        ST_PASS,
        ST_PRGA_J,
        ST_PRGA_SWAP,
        ST_PRGA_OUT
    } t_state;

endpackage

`default_nettype wire

/* hdl/rc4_stream_cipher_unit.sv */
// channel  | direction | tdata               | tuser        | tlast
// ---------+-----------+---------------------+--------------+---------
// s        | in        | [7:0] byte_value    | [0] req_type | key_last
// m        | out       | [7:0] out_byte      | [0] key_ready| -
//
// after reset a pass loads the identity permutation; no beat is
// taken on s meanwhile. a key byte is stored while the key store has
// room. the last key byte adds an identity fill and the key schedule,
// each swap step running through KSA_RD, KSA_J, KSA_WN and KSA_WJ.
// a data byte needs two dependent table reads, a two-write swap and the
// keystream read, on the one read and one write port of the table
// memory; an unkeyed one passes unchanged. a full output register holds
// the engine in its last step until m takes the waiting beat.
`default_nettype none

module rc4_stream_cipher_unit #(
    parameter int KEY_BYTES_MAX = rc4sc_pkg::KEY_BYTES_MAX_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] byte_value
    input  wire logic [0:0] i_s_tuser,   // [0] req_type
    input  wire logic       i_s_tlast,
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic [0:0]      o_m_tuser    // [0] key_ready
);

    localparam int KW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
    localparam int CW = $clog2(KEY_BYTES_MAX + 1);
    localparam logic [CW-1:0] KEY_MAX = CW'(KEY_BYTES_MAX);
    localparam int AW = rc4sc_pkg::TABLE_AW;
    localparam int BW = rc4sc_pkg::BYTE_W;

    rc4sc_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_n, n_n;
    logic [KW-1:0] r_kpos, n_kpos;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic          r_keyed, n_keyed;
    logic          r_ovalid, n_ovalid;
    logic [BW-1:0] r_byte, n_byte;
    logic [BW-1:0] r_si, n_si;
    logic [BW-1:0] r_sj, n_sj;
    logic [AW-1:0] r_t, n_t;
    logic [BW-1:0] r_odata, n_odata;
    logic          r_okey, n_okey;

    logic          p_we;
    logic [AW-1:0] p_waddr, p_raddr;
    logic [BW-1:0] p_wdata, p_rdata;
    logic          k_we;
    logic [KW-1:0] k_waddr, k_raddr;
    logic [BW-1:0] k_wdata, k_rdata;

    logic          s_accept;
    logic          out_free;
    logic          key_room;
    logic [AW-1:0] jn_ksa, jn_prga, t_idx;
    logic [BW-1:0] ks_byte;
    logic [CW-1:0] key_len;
    logic [CW-1:0] kpos_inc;

    // permutation table
    rc4sc_ram #(
        .WIDTH (BW),
        .DEPTH (rc4sc_pkg::TABLE_SIZE)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    // key store
    rc4sc_ram #(
        .WIDTH (BW),
        .DEPTH (KEY_BYTES_MAX)
    ) u_key (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (k_waddr),
        .i_wdata (k_wdata),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    // handshake and shared arithmetic
    assign o_s_tready = (r_state == rc4sc_pkg::ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ovalid || i_m_tready;
    assign key_room   = (r_count < KEY_MAX);
    assign jn_ksa     = r_j + p_rdata + k_rdata;
    assign jn_prga    = r_j + p_rdata;
    assign t_idx      = r_si + p_rdata;
    assign key_len    = (r_count == '0) ? CW'(1) : r_count;
    assign kpos_inc   = CW'(r_kpos) + CW'(1);

    // keystream byte with forwarding of the swap writes
    always_comb begin
        if (r_t == r_j) begin
            ks_byte = r_si;
        end else if (r_t == r_i) begin
            ks_byte = r_sj;
        end else begin
            ks_byte = p_rdata;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rc4sc_pkg::ST_CLEAR: begin
                if (r_n == rc4sc_pkg::TABLE_LAST) n_state = rc4sc_pkg::ST_IDLE;
            end
            rc4sc_pkg::ST_FILL: begin
                if (r_n == rc4sc_pkg::TABLE_LAST) n_state = rc4sc_pkg::ST_KSA_RD;
            end
            rc4sc_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (i_s_tuser[0] == rc4sc_pkg::REQ_KEY) begin
                        if (i_s_tlast) n_state = rc4sc_pkg::ST_FILL;
                    end else if (r_keyed) begin
                        n_state = rc4sc_pkg::ST_PRGA_J;
                    end else begin
                        n_state = rc4sc_pkg::ST_PASS;
                    end
                end
            end
            rc4sc_pkg::ST_PASS: begin
                if (out_free) n_state = rc4sc_pkg::ST_IDLE;
            end
            rc4sc_pkg::ST_KSA_RD:    n_state = rc4sc_pkg::ST_KSA_J;
            rc4sc_pkg::ST_KSA_J:     n_state = rc4sc_pkg::ST_KSA_WN;
            rc4sc_pkg::ST_KSA_WN:    n_state = rc4sc_pkg::ST_KSA_WJ;
            rc4sc_pkg::ST_KSA_WJ: begin
                if (r_n == rc4sc_pkg::TABLE_LAST) begin
                    n_state = rc4sc_pkg::ST_IDLE;
                end else begin
                    n_state = rc4sc_pkg::ST_KSA_RD;
                end
            end
            rc4sc_pkg::ST_PRGA_J:    n_state = rc4sc_pkg::ST_PRGA_SWAP;
            rc4sc_pkg::ST_PRGA_SWAP: n_state = rc4sc_pkg::ST_PRGA_OUT;
            rc4sc_pkg::ST_PRGA_OUT: begin
                if (out_free) n_state = rc4sc_pkg::ST_IDLE;
            end
            default: n_state = rc4sc_pkg::ST_CLEAR;
        endcase
    end

    // memory port controls
    always_comb begin
        p_we    = 1'b0;
        p_waddr = r_n;
        p_wdata = r_n;
        p_raddr = r_n;
        k_we    = 1'b0;
        k_waddr = r_count[KW-1:0];
        k_wdata = i_s_tdata;
        k_raddr = r_kpos;
        case (r_state)
            rc4sc_pkg::ST_CLEAR, rc4sc_pkg::ST_FILL: begin
                p_we = 1'b1;
            end
            rc4sc_pkg::ST_IDLE: begin
                p_raddr = r_i + AW'(1);
                k_we    = s_accept && (i_s_tuser[0] == rc4sc_pkg::REQ_KEY) && key_room;
            end
            rc4sc_pkg::ST_KSA_J: begin
                p_raddr = jn_ksa;
            end
            rc4sc_pkg::ST_KSA_WN: begin
                p_we    = 1'b1;
                p_waddr = r_n;
                p_wdata = p_rdata;
                p_raddr = r_j;
            end
            rc4sc_pkg::ST_KSA_WJ: begin
                p_we    = 1'b1;
                p_waddr = r_j;
                p_wdata = r_si;
            end
            rc4sc_pkg::ST_PRGA_J: begin
                p_raddr = jn_prga;
            end
            rc4sc_pkg::ST_PRGA_SWAP: begin
                p_we    = 1'b1;
                p_waddr = r_i;
                p_wdata = p_rdata;
                p_raddr = t_idx;
            end
            rc4sc_pkg::ST_PRGA_OUT: begin
                p_we    = 1'b1;
                p_waddr = r_j;
                p_wdata = r_si;
                p_raddr = r_t;
            end
            default: begin
                p_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_n      = r_n;
        n_kpos   = r_kpos;
        n_count  = r_count;
        n_i      = r_i;
        n_j      = r_j;
        n_keyed  = r_keyed;
        n_byte   = r_byte;
        n_si     = r_si;
        n_sj     = r_sj;
        n_t      = r_t;
        n_odata  = r_odata;
        n_okey   = r_okey;
        n_ovalid = r_ovalid && !i_m_tready;
        case (r_state)
            rc4sc_pkg::ST_CLEAR, rc4sc_pkg::ST_FILL: begin
                n_n = r_n + AW'(1);
            end
            rc4sc_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_byte = i_s_tdata;
                    if (i_s_tuser[0] == rc4sc_pkg::REQ_KEY) begin
                        if (key_room) n_count = r_count + CW'(1);
                        if (i_s_tlast) begin
                            n_j    = '0;
                            n_kpos = '0;
                            n_n    = '0;
                        end
                    end else if (r_keyed) begin
                        n_i = r_i + AW'(1);
                    end
                end
            end
            rc4sc_pkg::ST_PASS: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_byte;
                    n_okey   = 1'b0;
                end
            end
            rc4sc_pkg::ST_KSA_J: begin
                n_j  = jn_ksa;
                n_si = p_rdata;
            end
            rc4sc_pkg::ST_KSA_WJ: begin
                n_n = r_n + AW'(1);
                if (kpos_inc >= key_len) begin
                    n_kpos = '0;
                end else begin
                    n_kpos = r_kpos + KW'(1);
                end
                if (r_n == rc4sc_pkg::TABLE_LAST) begin
                    n_keyed = 1'b1;
                    n_i     = '0;
                    n_j     = '0;
                    n_count = '0;
                end
            end
            rc4sc_pkg::ST_PRGA_J: begin
                n_j  = jn_prga;
                n_si = p_rdata;
            end
            rc4sc_pkg::ST_PRGA_SWAP: begin
                n_sj = p_rdata;
                n_t  = t_idx;
            end
            rc4sc_pkg::ST_PRGA_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_byte ^ ks_byte;
                    n_okey   = 1'b1;
                end
            end
            default: begin
                n_n = r_n;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rc4sc_pkg::ST_CLEAR;
            r_n      <= '0;
            r_kpos   <= '0;
            r_count  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_keyed  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_n      <= n_n;
            r_kpos   <= n_kpos;
            r_count  <= n_count;
            r_i      <= n_i;
            r_j      <= n_j;
            r_keyed  <= n_keyed;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_si    <= n_si;
        r_sj    <= n_sj;
        r_t     <= n_t;
        r_odata <= n_odata;
        r_okey  <= n_okey;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_okey;

endmodule

`default_nettype wire

/* hdl/rc4sc_ram.sv */
`default_nettype none

module rc4sc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port (old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/rc4sc_checker.sv */
`default_nettype none

module rc4sc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_tvalid,
    input wire logic       o_s_tready,
    input wire logic [0:0] i_s_tuser,
    input wire logic       i_s_tlast,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic [0:0] o_m_tuser
);

    // table load after reset keeps the input closed and the output empty
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!o_s_tready && !o_m_tvalid))
        else $error("beat activity right after reset");

    // a stalled output beat holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("output beat changed while stalled");

    // a key byte never produces an output beat
    a_key_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser[0] == rc4sc_pkg::REQ_KEY) &&
         !o_m_tvalid) |=> !o_m_tvalid)
        else $error("output beat from a key byte");

    // the last key byte starts the key schedule, closing the input
    a_sched_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser[0] == rc4sc_pkg::REQ_KEY) &&
         i_s_tlast) |=> !o_s_tready)
        else $error("input open during key schedule");

endmodule

bind rc4_stream_cipher_unit rc4sc_checker u_rc4sc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
